FILE: rtl/hufd_pkg.sv
// huffman tree decoder package: default sizes, stream word layout, command codes
// no dependencies; used by huffman_tree_decoder_unit
package hufd_pkg;

  localparam int DEF_NODE_COUNT    = 512;
  localparam int DEF_MAX_CODE_BITS = 16;
  localparam int DEF_SYMBOL_BITS   = 8;

  localparam int CODE_W      = 16;
  localparam int CODE_LEN_W  = 5;
  localparam int SYM_IN_W    = 8;
  localparam int ENC_W       = 8;
  localparam int VALID_W     = 4;
  localparam int SYM_OUT_W   = 8;
  localparam int CMD_W       = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam int CODE_LSB    = 0;
  localparam int LEN_LSB     = CODE_LSB + CODE_W;
  localparam int SYM_LSB     = LEN_LSB + CODE_LEN_W;
  localparam int ENC_LSB     = SYM_LSB + SYM_IN_W;
  localparam int VALID_LSB   = ENC_LSB + ENC_W;

  localparam logic [VALID_W-1:0] MAX_VALID = VALID_W'(ENC_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

endpackage

FILE: rtl/hufd_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module hufd_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/huffman_tree_decoder_unit.sv
// huffman decoder top level: command sequencer walking a code tree in node memory
// depends on hufd_pkg and hufd_ram
//
// Takes one command word at a time; s_tready is high only while the unit is idle, and a
// finished result may still wait on the master side while the next word is taken. All tree
// work runs through one node memory with one read and one write per cycle, and every step
// waits on its registered read. Clear rewrites the root (other nodes are reopened on
// allocation); the same pass runs after reset. Load reads and checks each node on the code
// path (S_LRD, S_LCHK), opens a child pair in S_LZ0 and S_LZ1 where needed and writes the
// symbol at the final node. Decode fetches the walk node (S_DFETCH, S_DCUR) at the start of
// each word and after each leaf, takes each valid bit through S_DSTEP and S_DCHILD (S_DSTEP
// alone at the empty root) and ends the word in S_DEND. A leaf waits while the output
// register and the one pending result are both full. Every result carries its symbol in
// m_tdata, an unassigned leaf in m_tuser and the final result of a decode word in m_tlast.
module huffman_tree_decoder_unit #(
  parameter int NODE_COUNT    = hufd_pkg::DEF_NODE_COUNT,
  parameter int MAX_CODE_BITS = hufd_pkg::DEF_MAX_CODE_BITS,
  parameter int SYMBOL_BITS   = hufd_pkg::DEF_SYMBOL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // code_bits, code_length, symbol_in, enc_byte, valid_bits, zero fill
  input  logic [hufd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // cmd
  input  logic [hufd_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // symbol
  output logic [hufd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // bad_code
  output logic                              m_tuser,
  output logic                              m_tlast
);

  import hufd_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int NF_W  = $clog2(NODE_COUNT + 1);
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int CSR_W = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;

  typedef struct packed {
    logic                   inner;
    logic [IDX_W-1:0]       child;
    logic                   assigned;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic [SYM_OUT_W-1:0] sym;
    logic                 bad;
  } result_t;

  typedef enum logic [10:0] {
    S_CLR    = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_LRD    = 11'b000_0000_0100,
    S_LCHK   = 11'b000_0000_1000,
    S_LZ0    = 11'b000_0001_0000,
    S_LZ1    = 11'b000_0010_0000,
    S_DFETCH = 11'b000_0100_0000,
    S_DCUR   = 11'b000_1000_0000,
    S_DSTEP  = 11'b001_0000_0000,
    S_DCHILD = 11'b010_0000_0000,
    S_DEND   = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [NF_W-1:0]        nf;
  logic [IDX_W-1:0]       walk;
  logic [IDX_W-1:0]       lpos;
  logic [IDX_W-1:0]       alloc;
  logic [IDX_W-1:0]       cpos;
  logic [LEN_W-1:0]       llen;
  logic [LEN_W-1:0]       lcnt;
  logic [CSR_W-1:0]       code_sr;
  logic [SYMBOL_BITS-1:0] lsym;
  logic [ENC_W-1:0]       byte_sr;
  logic [VALID_W-1:0]     vb;
  logic [VALID_W-1:0]     dcnt;
  node_t                  cur;

  logic    pend_valid;
  result_t pend;
  logic    out_valid;
  result_t out_res;
  logic    out_last;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  node_t            wr_node;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [NODE_W-1:0] rd_raw;
  node_t            rd_node;

  logic             in_acc;
  logic             lbit;
  logic             dbit;
  logic [IDX_W-1:0] lbit_ext;
  logic [IDX_W-1:0] dbit_ext;
  logic             out_free;
  logic             can_hit;
  logic             nf_full;
  logic [VALID_W-1:0] vb_in;
  logic [LEN_W-1:0]   len_in;
  result_t          hit_res;

  assign rd_node  = node_t'(rd_raw);
  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign lbit     = code_sr[MAX_CODE_BITS-1];
  assign dbit     = byte_sr[ENC_W-1];
  assign lbit_ext = {{(IDX_W-1){1'b0}}, lbit};
  assign dbit_ext = {{(IDX_W-1){1'b0}}, dbit};
  assign out_free = !out_valid || m_tready;
  assign can_hit  = !pend_valid || out_free;
  assign nf_full  = (32'(nf) + 1) >= NODE_COUNT;

  assign vb_in  = (s_tdata[VALID_LSB +: VALID_W] > MAX_VALID) ? MAX_VALID
                                                              : s_tdata[VALID_LSB +: VALID_W];
  assign len_in = (32'(s_tdata[LEN_LSB +: CODE_LEN_W]) > MAX_CODE_BITS)
                ? LEN_W'(MAX_CODE_BITS) : LEN_W'(s_tdata[LEN_LSB +: CODE_LEN_W]);

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.sym;
  assign m_tuser  = out_res.bad;
  assign m_tlast  = out_last;

  hufd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // result of a leaf: the child read in S_DCHILD, else unassigned (empty tree in S_DSTEP)
  always_comb begin
    hit_res.sym = '0;
    hit_res.bad = 1'b1;
    if (state == S_DCHILD && rd_node.assigned) begin
      hit_res.sym = SYM_OUT_W'(rd_node.sym);
      hit_res.bad = 1'b0;
    end
  end

  // node memory ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_node = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_CLR: begin
        wr_en = 1'b1;
      end
      S_LRD: begin
        rd_en   = 1'b1;
        rd_addr = lpos;
      end
      S_LCHK: begin
        wr_addr = lpos;
        if (lcnt == llen) begin
          wr_en   = 1'b1;
          wr_node = '{inner: rd_node.inner, child: rd_node.child,
                      assigned: 1'b1, sym: lsym};
        end else if (!rd_node.inner && !nf_full) begin
          wr_en   = 1'b1;
          wr_node = '{inner: 1'b1, child: nf[IDX_W-1:0],
                      assigned: rd_node.assigned, sym: rd_node.sym};
        end
      end
      S_LZ0: begin
        wr_en   = 1'b1;
        wr_addr = alloc;
      end
      S_LZ1: begin
        wr_en   = 1'b1;
        wr_addr = alloc + IDX_W'(1);
      end
      S_DFETCH: begin
        rd_en   = (dcnt != vb);
        rd_addr = walk;
      end
      S_DSTEP: begin
        rd_en   = (dcnt != vb) && cur.inner;
        rd_addr = cur.child + dbit_ext;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (m_tready) begin
      out_valid <= 1'b0;
    end
    case (state)
      S_CLR: begin
        nf    <= NF_W'(1);
        walk  <= '0;
        state <= S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(s_tuser))
            CMD_CLEAR: begin
              state <= S_CLR;
            end
            CMD_LOAD: begin
              llen    <= len_in;
              lcnt    <= '0;
              lpos    <= '0;
              code_sr <= CSR_W'(s_tdata[CODE_LSB +: CODE_W]);
              lsym    <= SYMBOL_BITS'(s_tdata[SYM_LSB +: SYM_IN_W]);
              state   <= (len_in == '0) ? S_IDLE : S_LRD;
            end
            CMD_DECODE: begin
              byte_sr <= s_tdata[ENC_LSB +: ENC_W];
              vb      <= vb_in;
              dcnt    <= '0;
              state   <= (vb_in == '0) ? S_IDLE : S_DFETCH;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
      end
      S_LRD: begin
        state <= S_LCHK;
      end
      S_LCHK: begin
        if (lcnt == llen) begin
          state <= S_IDLE;
        end else if (rd_node.inner) begin
          lpos    <= rd_node.child + lbit_ext;
          lcnt    <= lcnt + LEN_W'(1);
          code_sr <= code_sr << 1;
          state   <= S_LRD;
        end else if (nf_full) begin
          state <= S_IDLE;
        end else begin
          alloc <= nf[IDX_W-1:0];
          nf    <= nf + NF_W'(2);
          state <= S_LZ0;
        end
      end
      S_LZ0: begin
        state <= S_LZ1;
      end
      S_LZ1: begin
        lpos    <= alloc + lbit_ext;
        lcnt    <= lcnt + LEN_W'(1);
        code_sr <= code_sr << 1;
        state   <= S_LRD;
      end
      S_DFETCH: begin
        state <= (dcnt == vb) ? S_DEND : S_DCUR;
      end
      S_DCUR: begin
        cur   <= rd_node;
        state <= S_DSTEP;
      end
      S_DSTEP: begin
        if (dcnt == vb) begin
          state <= S_DEND;
        end else if (!cur.inner) begin
          if (can_hit) begin
            if (pend_valid) begin
              out_valid <= 1'b1;
              out_res   <= pend;
              out_last  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend       <= hit_res;
            walk       <= '0;
            dcnt       <= dcnt + VALID_W'(1);
            byte_sr    <= byte_sr << 1;
            state      <= S_DFETCH;
          end
        end else begin
          cpos  <= cur.child + dbit_ext;
          state <= S_DCHILD;
        end
      end
      S_DCHILD: begin
        if (!rd_node.inner) begin
          if (can_hit) begin
            if (pend_valid) begin
              out_valid <= 1'b1;
              out_res   <= pend;
              out_last  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend       <= hit_res;
            walk       <= '0;
            dcnt       <= dcnt + VALID_W'(1);
            byte_sr    <= byte_sr << 1;
            state      <= S_DFETCH;
          end
        end else begin
          walk    <= cpos;
          cur     <= rd_node;
          dcnt    <= dcnt + VALID_W'(1);
          byte_sr <= byte_sr << 1;
          state   <= S_DSTEP;
        end
      end
      S_DEND: begin
        if (!pend_valid) begin
          state <= S_IDLE;
        end else if (out_free) begin
          out_valid  <= 1'b1;
          out_res    <= pend;
          out_last   <= 1'b1;
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase
    if (rst) begin
      state      <= S_CLR;
      nf         <= NF_W'(1);
      walk       <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// self-checking bench for huffman_tree_decoder_unit: tree loads and byte decodes through the
// stream ports, each symbol checked against a local copy of the code tree
// depends on hufd_pkg and the decoder rtl
module tb;
  import hufd_pkg::*;

  localparam int NODES = DEF_NODE_COUNT;
  localparam int CODE_MAX = DEF_MAX_CODE_BITS;
  localparam int RANDOM_WORDS = 195;

  typedef struct packed {
    logic [SYM_OUT_W-1:0] symbol;
    logic                 bad;
    logic                 last;
  } sym_word_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    int                len;
  } code_leaf_t;

  class decode_tracker;
    bit                   node_inner [NODES];
    int unsigned          node_child [NODES];
    bit                   node_set [NODES];
    logic [SYM_OUT_W-1:0] node_sym [NODES];
    int unsigned          free_ptr;
    int unsigned          walk_at;
    sym_word_t            due_symbols [$];
    int errors, n_load, n_decode, n_clear, n_ignored, n_full_stop, n_checked, n_bad;

    function new();
      clear_tree();
    endfunction

    function void clear_tree();
      for (int i = 0; i < NODES; i++) begin
        node_inner[i] = 0;
        node_child[i] = 0;
        node_set[i] = 0;
        node_sym[i] = '0;
      end
      free_ptr = 1;
      walk_at = 0;
    endfunction

    function void add_code(logic [CODE_W-1:0] code, logic [CODE_LEN_W-1:0] len_in,
                           logic [SYM_IN_W-1:0] sym);
      int unsigned len, pos, a;
      len = 32'(len_in);
      pos = 0;
      if (len == 0) return;
      if (len > CODE_MAX) len = CODE_MAX;
      for (int i = 0; i < len; i++) begin
        if (!node_inner[pos]) begin
          a = free_ptr;
          if (a + 1 >= NODES) begin
            n_full_stop++;
            return;
          end
          node_inner[a] = 0;
          node_child[a] = 0;
          node_set[a] = 0;
          node_sym[a] = '0;
          node_inner[a+1] = 0;
          node_child[a+1] = 0;
          node_set[a+1] = 0;
          node_sym[a+1] = '0;
          node_inner[pos] = 1;
          node_child[pos] = a;
          free_ptr = a + 2;
        end
        pos = node_child[pos] + code[CODE_MAX-1-i];
        if (pos >= NODES) return;
      end
      node_set[pos] = 1;
      node_sym[pos] = sym;
    endfunction

    function void walk_byte(logic [ENC_W-1:0] enc, logic [VALID_W-1:0] vb_in);
      int unsigned vb, pos;
      bit hit;
      sym_word_t w;
      sym_word_t found [$];
      vb = 32'(vb_in);
      if (vb > ENC_W) vb = ENC_W;
      for (int i = 0; i < vb; i++) begin
        pos = walk_at;
        if (pos >= NODES) pos = 0;
        hit = 0;
        w.symbol = '0;
        w.bad = 1'b1;
        w.last = 1'b0;
        if (!node_inner[pos]) begin
          hit = 1;
          walk_at = 0;
        end else begin
          pos = node_child[pos] + enc[ENC_W-1-i];
          if (pos >= NODES) pos = 0;
          if (!node_inner[pos]) begin
            hit = 1;
            if (node_set[pos]) begin
              w.symbol = node_sym[pos];
              w.bad = 1'b0;
            end
            walk_at = 0;
          end else begin
            walk_at = pos;
          end
        end
        if (hit) found.push_back(w);
      end
      foreach (found[k]) begin
        w = found[k];
        w.last = (k == found.size() - 1);
        due_symbols.push_back(w);
      end
    endfunction

    function void absorb_word(cmd_t c, logic [IN_TDATA_W-1:0] d);
      case (c)
        CMD_CLEAR: begin
          n_clear++;
          clear_tree();
        end
        CMD_LOAD: begin
          n_load++;
          add_code(d[CODE_LSB +: CODE_W], d[LEN_LSB +: CODE_LEN_W], d[SYM_LSB +: SYM_IN_W]);
        end
        CMD_DECODE: begin
          n_decode++;
          walk_byte(d[ENC_LSB +: ENC_W], d[VALID_LSB +: VALID_W]);
        end
        default: n_ignored++;
      endcase
    endfunction

    function void match_symbol(logic [SYM_OUT_W-1:0] s, logic b, logic l);
      sym_word_t w;
      if (due_symbols.size() == 0) begin
        $error("unexpected symbol %0h bad_code %0b last %0b", s, b, l);
        errors++;
        return;
      end
      w = due_symbols.pop_front();
      if (s !== w.symbol) begin
        $error("symbol mismatch: expected %0h, got %0h", w.symbol, s);
        errors++;
      end
      if (b !== w.bad) begin
        $error("bad_code mismatch: expected %0b, got %0b", w.bad, b);
        errors++;
      end
      if (l !== w.last) begin
        $error("last mismatch: expected %0b, got %0b", w.last, l);
        errors++;
      end
      n_checked++;
      if (w.bad) n_bad++;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = CMD_NOP;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  decode_tracker tracker;
  int n_words = 0;
  bit steady = 0;
  bit rx_calm = 0;
  int rx_hold = 0;
  int rx_cycle = 0;

  huffman_tree_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(16, 40);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_word(logic [CODE_W-1:0] code,
      logic [CODE_LEN_W-1:0] len, logic [SYM_IN_W-1:0] sym, logic [ENC_W-1:0] enc,
      logic [VALID_W-1:0] vb);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[CODE_LSB +: CODE_W] = code;
    d[LEN_LSB +: CODE_LEN_W] = len;
    d[SYM_LSB +: SYM_IN_W] = sym;
    d[ENC_LSB +: ENC_W] = enc;
    d[VALID_LSB +: VALID_W] = vb;
    return d;
  endfunction

  task automatic send_word(input cmd_t c, input logic [IN_TDATA_W-1:0] d);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 45) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= c;
    do @(posedge clk); while (!s_tready);
    tracker.absorb_word(c, d);
    if (c != CMD_NOP) n_words++;
  endtask

  task automatic load_word(input logic [CODE_W-1:0] code, input int len, input int sym);
    send_word(CMD_LOAD, pack_word(code, len[CODE_LEN_W-1:0], sym[SYM_IN_W-1:0],
                                  ENC_W'($urandom), VALID_W'($urandom)));
  endtask

  task automatic decode_word(input logic [ENC_W-1:0] enc, input logic [VALID_W-1:0] vb);
    send_word(CMD_DECODE, pack_word(CODE_W'($urandom), CODE_LEN_W'($urandom),
                                    SYM_IN_W'($urandom), enc, vb));
  endtask

  task automatic clear_word();
    send_word(CMD_CLEAR, pack_word(CODE_W'($urandom), CODE_LEN_W'($urandom),
                                   SYM_IN_W'($urandom), ENC_W'($urandom), VALID_W'($urandom)));
  endtask

  task automatic noise_word();
    int r;
    cmd_t c;
    r = $urandom_range(0, 19);
    c = (r == 0) ? CMD_CLEAR : (r < 8) ? CMD_LOAD : (r < 17) ? CMD_DECODE : CMD_NOP;
    send_word(c, pack_word(CODE_W'($urandom), CODE_LEN_W'($urandom), SYM_IN_W'($urandom),
                           ENC_W'($urandom), VALID_W'($urandom)));
  endtask

  // random prefix-free code set grown by splitting leaves, loaded in random order
  task automatic load_code_set();
    code_leaf_t leaves [$];
    code_leaf_t lf, tmp;
    int target, maxlen, idx, j, skip;
    bit skew;
    lf.code = '0;
    lf.len = 0;
    leaves.push_back(lf);
    target = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(2, 10);
    maxlen = ($urandom_range(0, 3) == 0) ? CODE_MAX : 8;
    skew = ($urandom_range(0, 2) == 0);
    for (int tries = 0; leaves.size() < target && tries < 200; tries++) begin
      idx = (skew && $urandom_range(0, 9) < 7) ? leaves.size() - 1
                                               : $urandom_range(0, leaves.size() - 1);
      if (leaves[idx].len < maxlen) begin
        lf = leaves[idx];
        tmp.code = lf.code;
        tmp.len = lf.len + 1;
        leaves[idx] = tmp;
        tmp.code = lf.code | (CODE_W'(1) << (CODE_W - 1 - lf.len));
        leaves.push_back(tmp);
      end
    end
    for (int i = leaves.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = leaves[i];
      leaves[i] = leaves[j];
      leaves[j] = tmp;
    end
    // sometimes leave one code out so its leaf stays unassigned
    skip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, leaves.size() - 1) : -1;
    foreach (leaves[i])
      if (i != skip) load_word(leaves[i].code, leaves[i].len, $urandom_range(0, 255));
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_symbol(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      rx_hold = idle_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    int start, kind;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty tree, zero and oversized valid counts, ignored command
    decode_word(8'hFF, 4'd8);
    decode_word(8'h00, 4'd0);
    decode_word(8'hA5, 4'd15);
    send_word(CMD_NOP, pack_word(16'hFFFF, 5'h1F, 8'hFF, 8'hFF, 4'hF));
    // zero length, over-long code, code ending on an inner node
    load_word(16'hFFFF, 0, 'h55);
    load_word(16'hFFFF, 31, 'hFF);
    load_word(16'h8000, 1, 'h80);
    load_word(16'h0000, 1, 'h00);
    // partial walk kept across bytes
    decode_word(8'h7F, 4'd8);
    decode_word(8'hFF, 4'd8);
    decode_word(8'h80, 4'd1);
    // code passing an assigned leaf
    load_word(16'h4000, 2, 'h22);
    decode_word(8'h00, 4'd4);
    decode_word(8'h40, 4'd2);
    // load while a walk is partway down
    decode_word(8'hC0, 4'd2);
    load_word(16'hA000, 3, 'h5A);
    decode_word(8'h00, 4'd8);
    clear_word();
    decode_word(8'h80, 4'd1);
    load_word(16'h0000, 16, 'h01);
    load_word(16'hFFFF, 16, 'hFE);
    decode_word(8'h00, 4'd8);
    decode_word(8'h00, 4'd8);
    decode_word(8'hFF, 4'd8);
    decode_word(8'hFF, 4'd8);

    start = n_words;
    while (n_words < start + RANDOM_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        if ($urandom_range(0, 4) != 0) clear_word();
        load_code_set();
        repeat ($urandom_range(3, 12))
          decode_word(ENC_W'($urandom),
                      VALID_W'(($urandom_range(0, 9) < 7) ? 8 : $urandom_range(1, 8)));
      end else if (kind < 88) begin
        repeat ($urandom_range(3, 8)) noise_word();
      end else begin
        // long random codes until the node store runs out
        clear_word();
        repeat (22) load_word(CODE_W'($urandom), $urandom_range(14, 31), $urandom_range(0, 255));
        repeat (4) decode_word(ENC_W'($urandom), 4'd8);
      end
    end
    s_tvalid <= 1'b0;

    while (tracker.due_symbols.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d words: %0d loads (%0d stopped on a full node store), %0d decodes, %0d clears",
             n_words, tracker.n_load, tracker.n_full_stop, tracker.n_decode, tracker.n_clear);
    $display("%0d symbols checked, %0d from unassigned leaves, %0d ignored commands",
             tracker.n_checked, tracker.n_bad, tracker.n_ignored);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
